>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the luma auto-exposure tuner.
// No dependencies; define SYNTH to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: property does not hold");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> src/laet_pkg.sv
// Shared types, constants and helpers for the luma auto-exposure tuner.
// No dependencies.
package laet_pkg;

    localparam int PIXEL_W    = 8;
    localparam int MEAN_W     = 8;
    localparam int TARGET_W   = 8;
    localparam int DB_W       = 7;
    localparam int DIVIDER_W  = 5;
    localparam int EXP_W      = 11;
    localparam int GAIN_W     = 7;
    localparam int CEIL_W     = 3;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [EXP_W-1:0]     EXP_MIN   = 11'd50;
    localparam logic [EXP_W-1:0]     EXP_MAX   = 11'd1200;
    localparam logic [EXP_W-1:0]     EXP_STEP  = 11'd20;
    localparam logic [GAIN_W-1:0]    GAIN_CAP  = 7'd64;
    localparam logic [DB_W-1:0]      DB_MAX    = 7'd64;
    localparam logic [DIVIDER_W-1:0] DIV_MAX   = 5'd30;

    localparam logic [TARGET_W-1:0]  TARGET_RST     = 8'd128;
    localparam logic [DB_W-1:0]      DB_RST         = 7'd10;
    localparam logic [DIVIDER_W-1:0] DIVIDER_RST    = 5'd5;
    localparam logic [EXP_W-1:0]     EXP_START_RST  = 11'd300;
    localparam logic [GAIN_W-1:0]    GAIN_START_RST = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_LEVEL     = 3'd0,
        REG_LUMA_DEADBAND    = 3'd1,
        REG_TUNE_DIVIDER     = 3'd2,
        REG_AUTO_TUNE        = 3'd3,
        REG_AUTO_EXPOSURE    = 3'd4,
        REG_AUTO_GAIN        = 3'd5,
        REG_EXPOSURE_START   = 3'd6,
        REG_GAIN_START       = 3'd7
    } cfg_reg_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE     = 2'd0,
        DIR_DARKER   = 2'd1,
        DIR_BRIGHTER = 2'd2
    } dir_t;

    typedef enum logic [CEIL_W-1:0] {
        CEIL_2X  = 3'd0,
        CEIL_4X  = 3'd1,
        CEIL_8X  = 3'd2,
        CEIL_16X = 3'd3,
        CEIL_32X = 3'd4,
        CEIL_64X = 3'd5
    } ceil_t;

    typedef struct packed {
        logic [TARGET_W-1:0]  target_level;
        logic [DB_W-1:0]      luma_deadband;
        logic [DIVIDER_W-1:0] tune_divider;
        logic                 auto_tune_enable;
        logic                 auto_exposure_enable;
        logic                 auto_gain_enable;
    } cfg_t;

    // start-value writes reload the limit state directly
    typedef struct packed {
        logic              exp_load;
        logic              gain_load;
        logic [EXP_W-1:0]  exp_value;
        logic [GAIN_W-1:0] gain_value;
    } start_load_t;

    function automatic ceil_t ceiling_code(input logic [GAIN_W-1:0] gain);
        ceil_t code;
        if (gain <= 7'd2)
            code = CEIL_2X;
        else if (gain <= 7'd4)
            code = CEIL_4X;
        else if (gain <= 7'd8)
            code = CEIL_8X;
        else if (gain <= 7'd16)
            code = CEIL_16X;
        else if (gain <= 7'd32)
            code = CEIL_32X;
        else
            code = CEIL_64X;
        return code;
    endfunction

endpackage

>>> src/laet_cfg.sv
// Configuration register file of the luma auto-exposure tuner.
// Depends on laet_pkg.
module laet_cfg
    import laet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output start_load_t           load
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level         <= TARGET_RST;
            cfg_reg.luma_deadband        <= DB_RST;
            cfg_reg.tune_divider         <= DIVIDER_RST;
            cfg_reg.auto_tune_enable     <= 1'b1;
            cfg_reg.auto_exposure_enable <= 1'b0;
            cfg_reg.auto_gain_enable     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_TARGET_LEVEL:   cfg_reg.target_level  <= cfg_data[TARGET_W-1:0];
                REG_LUMA_DEADBAND:  cfg_reg.luma_deadband <= cfg_data[DB_W-1:0];
                REG_TUNE_DIVIDER:   cfg_reg.tune_divider  <= cfg_data[DIVIDER_W-1:0];
                REG_AUTO_TUNE:      cfg_reg.auto_tune_enable     <= cfg_data[0];
                REG_AUTO_EXPOSURE:  cfg_reg.auto_exposure_enable <= cfg_data[0];
                REG_AUTO_GAIN:      cfg_reg.auto_gain_enable     <= cfg_data[0];
                REG_EXPOSURE_START,
                REG_GAIN_START:     ;   // held as limit state in the tune stage
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    assign load.exp_load   = cfg_write && (cfg_index == REG_EXPOSURE_START);
    assign load.gain_load  = cfg_write && (cfg_index == REG_GAIN_START);
    assign load.exp_value  = cfg_data[EXP_W-1:0];
    assign load.gain_value = cfg_data[GAIN_W-1:0];

endmodule

>>> src/laet_acc.sv
// Input register, sampled luma accumulator and tuning-frame phase counter.
// Depends on laet_pkg; emits one divide job per tuning frame.
module laet_acc
    import laet_pkg::*;
#(
    parameter int FRAME_PIXELS = 4096,
    parameter int SAMPLE_STEP  = 8,
    parameter int CNT_W        = 10,
    parameter int SUM_W        = 17
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIXEL_W-1:0] pixel,
    input  logic               frame_end,
    output logic               job_valid,
    input  logic               job_ready,
    output logic [SUM_W-1:0]   job_sum,
    output logic [CNT_W-1:0]   job_count
);

    localparam int POS_W = $clog2(FRAME_PIXELS + 1);
    localparam int SUB_W = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;

    logic                 beat_valid_reg;
    logic [PIXEL_W-1:0]   pixel_reg;
    logic                 last_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [SUB_W-1:0]     sub_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [DIVIDER_W-1:0] phase_reg;

    logic                 take;
    logic                 sample;
    logic [POS_W-1:0]     pos_next;
    logic [SUB_W-1:0]     sub_next;
    logic [CNT_W-1:0]     cnt_next;
    logic [SUM_W-1:0]     sum_next;
    logic [DIVIDER_W-1:0] divider;
    logic [DIVIDER_W:0]   phase_inc;
    logic                 tune_frame;
    logic                 consume;

    // pixels past the frame size are dropped, position holds
    assign take   = pos_reg < POS_W'(FRAME_PIXELS);
    assign sample = take && (sub_reg == '0);

    always_comb
    begin
        pos_next = take ? pos_reg + POS_W'(1) : pos_reg;
        sum_next = sample ? sum_reg + SUM_W'(pixel_reg) : sum_reg;
        cnt_next = sample ? cnt_reg + CNT_W'(1) : cnt_reg;
        if (!take)
            sub_next = sub_reg;
        else if (sub_reg == SUB_W'(SAMPLE_STEP - 1))
            sub_next = '0;
        else
            sub_next = sub_reg + SUB_W'(1);
    end

    always_comb
    begin
        if (cfg.tune_divider == '0)
            divider = DIVIDER_W'(1);
        else if (cfg.tune_divider > DIV_MAX)
            divider = DIV_MAX;
        else
            divider = cfg.tune_divider;
    end

    // a phase left beyond the divider by a register change also tunes
    assign phase_inc  = {1'b0, phase_reg} + (DIVIDER_W+1)'(1);
    assign tune_frame = phase_inc >= {1'b0, divider};

    assign job_valid = beat_valid_reg && last_reg && tune_frame;
    assign job_sum   = sum_next;
    assign job_count = cnt_next;
    assign consume   = beat_valid_reg && (!job_valid || job_ready);
    assign in_stall  = job_valid && !job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
            pos_reg        <= '0;
            sub_reg        <= '0;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            phase_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
                beat_valid_reg <= in_valid;
            if (consume)
            begin
                if (last_reg)
                begin
                    pos_reg   <= '0;
                    sub_reg   <= '0;
                    cnt_reg   <= '0;
                    sum_reg   <= '0;
                    phase_reg <= tune_frame ? '0 : phase_inc[DIVIDER_W-1:0];
                end
                else
                begin
                    pos_reg <= pos_next;
                    sub_reg <= sub_next;
                    cnt_reg <= cnt_next;
                    sum_reg <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            pixel_reg <= pixel;
            last_reg  <= frame_end;
        end
    end

endmodule

>>> src/laet_div.sv
// Pipelined restoring divider: sampled luma sum over sample count.
// Depends on laet_pkg; after a load stage, one quotient bit per stage; stalls stage by stage.
module laet_div
    import laet_pkg::*;
#(
    parameter int CNT_W = 10,
    parameter int SUM_W = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  logic [SUM_W-1:0]  job_sum,
    input  logic [CNT_W-1:0]  job_count,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [MEAN_W-1:0] res_mean
);

    // sum < 256 * count, so eight quotient bits are enough
    localparam int REM_W = CNT_W + MEAN_W;
    localparam int NSTG  = MEAN_W + 1;

    logic              vld_reg [NSTG];
    logic [MEAN_W-1:0] quo_reg [NSTG];
    logic [REM_W-1:0]  rem_reg [NSTG-1];
    logic [CNT_W-1:0]  den_reg [NSTG-1];
    logic [NSTG:0]     ready;

    assign ready[NSTG] = res_ready;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stage
            assign ready[k] = !vld_reg[k] || ready[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (ready[k])
                    vld_reg[k] <= (k == 0) ? job_valid : vld_reg[(k == 0) ? 0 : k-1];
            end

            if (k == 0)
            begin : g_load
                always_ff @(posedge clk)
                begin
                    if (ready[0])
                    begin
                        rem_reg[0] <= REM_W'(job_sum);
                        den_reg[0] <= job_count;
                        quo_reg[0] <= '0;
                    end
                end
            end
            else
            begin : g_step
                localparam int BIT = MEAN_W - k;
                logic [REM_W-1:0] shifted;
                logic             ge;

                assign shifted = REM_W'(den_reg[k-1]) << BIT;
                assign ge      = rem_reg[k-1] >= shifted;

                always_ff @(posedge clk)
                begin
                    if (ready[k])
                        quo_reg[k] <= quo_reg[k-1] | (MEAN_W'(ge) << BIT);
                end

                if (k < NSTG - 1)
                begin : g_carry
                    always_ff @(posedge clk)
                    begin
                        if (ready[k])
                        begin
                            rem_reg[k] <= ge ? rem_reg[k-1] - shifted : rem_reg[k-1];
                            den_reg[k] <= den_reg[k-1];
                        end
                    end
                end
            end
        end
    endgenerate

    assign job_ready = ready[0];
    assign res_valid = vld_reg[NSTG-1];
    assign res_mean  = quo_reg[NSTG-1];

endmodule

>>> src/laet_tune.sv
// Limit state, deadband compare and result register of the tuner.
// Depends on laet_pkg and assert_macros.svh.
`include "assert_macros.svh"

module laet_tune
    import laet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  start_load_t       load,
    input  logic              res_valid,
    output logic              res_ready,
    input  logic [MEAN_W-1:0] res_mean,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [MEAN_W-1:0] avg_luma,
    output logic [EXP_W-1:0]  exposure_limit,
    output logic [GAIN_W-1:0] gain_limit,
    output logic [CEIL_W-1:0] gain_ceiling,
    output logic              apply_exposure,
    output logic              apply_gain,
    output logic [DIR_W-1:0]  adjust_direction
);

    logic              out_valid_reg;
    logic [MEAN_W-1:0] mean_reg;
    dir_t              dir_reg;
    logic [EXP_W-1:0]  exposure_state_reg;
    logic [GAIN_W-1:0] gain_state_reg;

    dir_t              dir_next;
    logic [EXP_W-1:0]  exposure_state_next;
    logic [GAIN_W-1:0] gain_state_next;
    logic [DB_W-1:0]   db;
    logic [MEAN_W+1:0] mean_ext;
    logic [MEAN_W+1:0] target_ext;
    logic [MEAN_W+1:0] db_ext;
    logic              take_res;
    logic [EXP_W-1:0]  exp_load_val;
    logic [GAIN_W-1:0] gain_load_val;

    assign res_ready = !out_valid_reg || !out_stall;
    assign take_res  = res_valid && res_ready;

    assign db         = (cfg.luma_deadband > DB_MAX) ? DB_MAX : cfg.luma_deadband;
    assign mean_ext   = (MEAN_W+2)'(res_mean);
    assign target_ext = (MEAN_W+2)'(cfg.target_level);
    assign db_ext     = (MEAN_W+2)'(db);

    // mean < target - db is rewritten as mean + db < target to stay unsigned
    always_comb
    begin
        dir_next = DIR_NONE;
        if (cfg.auto_tune_enable)
        begin
            if (mean_ext > target_ext + db_ext)
                dir_next = DIR_DARKER;
            else if (mean_ext + db_ext < target_ext)
                dir_next = DIR_BRIGHTER;
        end
    end

    // state is always held in range, so only one side of each clamp matters
    always_comb
    begin
        exposure_state_next = exposure_state_reg;
        gain_state_next     = gain_state_reg;
        case (dir_next)
            DIR_DARKER:
            begin
                exposure_state_next = (exposure_state_reg < EXP_MIN + EXP_STEP) ?
                                      EXP_MIN : exposure_state_reg - EXP_STEP;
                gain_state_next     = (gain_state_reg == '0) ?
                                      '0 : gain_state_reg - GAIN_W'(1);
            end
            DIR_BRIGHTER:
            begin
                exposure_state_next = (exposure_state_reg > EXP_MAX - EXP_STEP) ?
                                      EXP_MAX : exposure_state_reg + EXP_STEP;
                gain_state_next     = (gain_state_reg >= GAIN_CAP) ?
                                      GAIN_CAP : gain_state_reg + GAIN_W'(1);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (load.exp_value < EXP_MIN)
            exp_load_val = EXP_MIN;
        else if (load.exp_value > EXP_MAX)
            exp_load_val = EXP_MAX;
        else
            exp_load_val = load.exp_value;
        gain_load_val = (load.gain_value > GAIN_CAP) ? GAIN_CAP : load.gain_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            dir_reg            <= DIR_NONE;
            exposure_state_reg <= EXP_START_RST;
            gain_state_reg     <= GAIN_START_RST;
        end
        else
        begin
            if (res_ready)
                out_valid_reg <= res_valid;
            if (take_res)
            begin
                dir_reg            <= dir_next;
                exposure_state_reg <= exposure_state_next;
                gain_state_reg     <= gain_state_next;
            end
            else
            begin
                if (load.exp_load)
                    exposure_state_reg <= exp_load_val;
                if (load.gain_load)
                    gain_state_reg <= gain_load_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_res)
            mean_reg <= res_mean;
    end

    // limits are read straight from state: it only moves when a result is taken or a start value is written
    assign out_valid        = out_valid_reg;
    assign avg_luma         = mean_reg;
    assign exposure_limit   = exposure_state_reg;
    assign gain_limit       = gain_state_reg;
    assign gain_ceiling     = ceiling_code(gain_state_reg);
    assign apply_exposure   = !cfg.auto_exposure_enable;
    assign apply_gain       = !cfg.auto_gain_enable;
    assign adjust_direction = dir_reg;

    `ASSERT_ALWAYS(a_exp_in_range, clk, rst_n, (exposure_state_reg >= EXP_MIN) && (exposure_state_reg <= EXP_MAX))
    `ASSERT_NEVER(a_gain_over_max, clk, rst_n, gain_state_reg > GAIN_CAP)
    `ASSERT_NEVER(a_dir_illegal, clk, rst_n, out_valid_reg && (dir_reg != DIR_NONE) && (dir_reg != DIR_DARKER) && (dir_reg != DIR_BRIGHTER))
    `ASSERT_ALWAYS(a_no_step_when_off, clk, rst_n, (take_res && !cfg.auto_tune_enable) |=> (dir_reg == DIR_NONE))
    `ASSERT_ALWAYS(a_darker_lowers, clk, rst_n, (take_res && (dir_next == DIR_DARKER)) |=> (exposure_state_reg <= $past(exposure_state_reg)))

endmodule

>>> src/luma_auto_exposure_tuner_unit.sv
// Luma auto-exposure tuner: accumulates sampled pixel luma over a frame and,
// on tuning frames, steps the exposure and gain limits around a target band.
// Throughput is one pixel beat per cycle while in_stall is low, frame end beats
// included, with no gaps needed between frames. out_valid rises after a tuning
// frame's last beat passes the input register, the divider load stage, the eight
// divider stages and the result register. The mean is formed by that pipelined
// divider, one quotient bit per stage. Up to ten results are held (nine divider
// stages and the result register), so a stalled output only backs up the input
// once they are all full and another tuning frame ends.
// Depends on laet_pkg, laet_cfg, laet_acc, laet_div and laet_tune.
module luma_auto_exposure_tuner_unit
    import laet_pkg::*;
#(
    parameter int FRAME_PIXELS = 4096,
    parameter int SAMPLE_STEP  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_W-1:0]    pixel,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MEAN_W-1:0]     avg_luma,
    output logic [EXP_W-1:0]      exposure_limit,
    output logic [GAIN_W-1:0]     gain_limit,
    output logic [CEIL_W-1:0]     gain_ceiling,
    output logic                  apply_exposure,
    output logic                  apply_gain,
    output logic [DIR_W-1:0]      adjust_direction
);

    localparam int MAX_CNT = (FRAME_PIXELS + SAMPLE_STEP - 1) / SAMPLE_STEP;
    localparam int CNT_W   = $clog2(MAX_CNT + 1);
    localparam int SUM_W   = $clog2(255 * MAX_CNT + 1);

    cfg_t              cfg;
    start_load_t       load;
    logic              job_valid;
    logic              job_ready;
    logic [SUM_W-1:0]  job_sum;
    logic [CNT_W-1:0]  job_count;
    logic              res_valid;
    logic              res_ready;
    logic [MEAN_W-1:0] res_mean;

    laet_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .load      (load)
    );

    laet_acc #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .SAMPLE_STEP  (SAMPLE_STEP),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .frame_end (frame_end),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_sum   (job_sum),
        .job_count (job_count)
    );

    laet_div #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_sum   (job_sum),
        .job_count (job_count),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_mean  (res_mean)
    );

    laet_tune u_tune (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .load             (load),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_mean         (res_mean),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .avg_luma         (avg_luma),
        .exposure_limit   (exposure_limit),
        .gain_limit       (gain_limit),
        .gain_ceiling     (gain_ceiling),
        .apply_exposure   (apply_exposure),
        .apply_gain       (apply_gain),
        .adjust_direction (adjust_direction)
    );

endmodule
